>>> sv/rne_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types, constants and symbol tables for the Roman numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

   localparam int VALUE_W     = 13;
   localparam int MAG_W       = 12;
   localparam int CHAR_W      = 8;
   localparam int SYM_IDX_W   = 4;
   localparam int SYM_VAL_W   = 10;
   localparam int NUM_SYMBOLS = 13;

   localparam logic [MAG_W-1:0]  MAX_MAG    = 12'd3999;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_I     = 8'h49;
   localparam logic [CHAR_W-1:0] CHAR_V     = 8'h56;
   localparam logic [CHAR_W-1:0] CHAR_X     = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_L     = 8'h4C;
   localparam logic [CHAR_W-1:0] CHAR_C     = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_D     = 8'h44;
   localparam logic [CHAR_W-1:0] CHAR_M     = 8'h4D;

   // Classified item passed from the front to the back through the queue
   typedef struct packed {
      logic             neg;
      logic             zero;
      logic [MAG_W-1:0] mag;
   } item_type;

   // Symbol values, index 0 = I up to index 12 = M
   function automatic logic [SYM_VAL_W-1:0] sym_val(input logic [SYM_IDX_W-1:0] idx);
      logic [SYM_VAL_W-1:0] v;
      unique case (idx)
         4'd0:    v = 10'd1;
         4'd1:    v = 10'd4;
         4'd2:    v = 10'd5;
         4'd3:    v = 10'd9;
         4'd4:    v = 10'd10;
         4'd5:    v = 10'd40;
         4'd6:    v = 10'd50;
         4'd7:    v = 10'd90;
         4'd8:    v = 10'd100;
         4'd9:    v = 10'd400;
         4'd10:   v = 10'd500;
         4'd11:   v = 10'd900;
         4'd12:   v = 10'd1000;
         default: v = '1;
      endcase
      return v;
   endfunction

   // Leading letter of each symbol
   function automatic logic [CHAR_W-1:0] sym_first(input logic [SYM_IDX_W-1:0] idx);
      logic [CHAR_W-1:0] c;
      unique case (idx)
         4'd0, 4'd1, 4'd3:   c = CHAR_I;
         4'd2:               c = CHAR_V;
         4'd4, 4'd5, 4'd7:   c = CHAR_X;
         4'd6:               c = CHAR_L;
         4'd8, 4'd9, 4'd11:  c = CHAR_C;
         4'd10:              c = CHAR_D;
         4'd12:              c = CHAR_M;
         default:            c = CHAR_NONE;
      endcase
      return c;
   endfunction

   // Trailing letter of subtractive pairs, CHAR_NONE for single letters
   function automatic logic [CHAR_W-1:0] sym_second(input logic [SYM_IDX_W-1:0] idx);
      logic [CHAR_W-1:0] c;
      unique case (idx)
         4'd1:    c = CHAR_V;
         4'd3:    c = CHAR_X;
         4'd5:    c = CHAR_L;
         4'd7:    c = CHAR_C;
         4'd9:    c = CHAR_D;
         4'd11:   c = CHAR_M;
         default: c = CHAR_NONE;
      endcase
      return c;
   endfunction

endpackage

>>> sv/rne_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rne_front
// Accepts input beats, takes the magnitude, saturates it and pushes the
// classified item into the queue.
// ----------------------------------------------------------------------------
module rne_front
   import rne_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [VALUE_W-1:0] req_value,
   output logic               req_stall,
   input  logic               q_full,
   output logic               q_push,
   output item_type           q_item
);

   logic             neg;
   logic [VALUE_W-1:0] mag_full;
   logic [MAG_W-1:0] mag_sat;

   // Take the magnitude; the most negative pattern gives 4096
   assign neg      = req_value[VALUE_W-1];
   assign mag_full = neg ? (VALUE_W'(0) - req_value) : req_value;

   // Clamp to the largest encodable magnitude
   assign mag_sat = (mag_full > {1'b0, MAX_MAG}) ? MAX_MAG : mag_full[MAG_W-1:0];

   // Accept whenever the queue has room
   assign req_stall   = q_full;
   assign q_push      = req_valid && !q_full;
   assign q_item.neg  = neg;
   assign q_item.mag  = mag_sat;
   assign q_item.zero = (mag_sat == '0);

   // A full queue is never pushed
   property p_no_push_full;
      @(posedge clock) disable iff (reset) q_full |-> !q_push;
   endproperty
   a_no_push_full: assert property (p_no_push_full)
      else $error("rne_front: push into a full queue");

endmodule

>>> sv/rne_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rne_queue
// Two-entry queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module rne_queue
   import rne_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   output logic     empty,
   input  logic     pop,
   output item_type pop_item
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_item = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed items
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> sv/rne_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rne_back
// Sequencer that turns one queued magnitude into a run of characters, one
// per cycle unless the output stalls, through a registered output stage.
// ----------------------------------------------------------------------------
module rne_back
   import rne_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  item_type          q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   output logic [CHAR_W-1:0] rsp_char_code,
   output logic              rsp_char_valid,
   output logic              rsp_last,
   input  logic              rsp_stall
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SIGN   = 5'b00010,
      ST_FIRST  = 5'b00100,
      ST_SECOND = 5'b01000,
      ST_ZERO   = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [MAG_W-1:0]     rem_ff, rem_in;
   logic [SYM_IDX_W-1:0] idx_ff, idx_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]    out_code_ff, out_code_in;
   logic                 out_cv_ff, out_cv_in;
   logic                 out_last_ff, out_last_in;

   logic                 emit;
   logic [SYM_IDX_W-1:0] sel;
   logic [MAG_W-1:0]     rem_sub;

   // Pick the largest symbol that still fits
   always_comb begin
      sel = '0;
      for (int i = 0; i < NUM_SYMBOLS; i++) begin
         if ({{(MAG_W-SYM_VAL_W){1'b0}}, sym_val(SYM_IDX_W'(i))} <= rem_ff) begin
            sel = SYM_IDX_W'(i);
         end
      end
   end

   assign rem_sub = rem_ff - {{(MAG_W-SYM_VAL_W){1'b0}}, sym_val(sel)};

   // A character may be produced when the output stage is free or draining
   assign emit  = (state_ff != ST_IDLE) && (!out_valid_ff || !rsp_stall);
   assign q_pop = (state_ff == ST_IDLE) && !q_empty;

   // Sequence the run
   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_code_in  = out_code_ff;
      out_cv_in    = out_cv_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               rem_in = q_item.mag;
               if (q_item.zero) begin
                  state_in = ST_ZERO;
               end else if (q_item.neg) begin
                  state_in = ST_SIGN;
               end else begin
                  state_in = ST_FIRST;
               end
            end
         end
         ST_SIGN: begin
            if (emit) begin
               out_valid_in = 1'b1;
               out_code_in  = CHAR_MINUS;
               out_cv_in    = 1'b1;
               out_last_in  = 1'b0;
               state_in     = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (emit) begin
               out_valid_in = 1'b1;
               out_code_in  = sym_first(sel);
               out_cv_in    = 1'b1;
               rem_in       = rem_sub;
               idx_in       = sel;
               if (sym_second(sel) != CHAR_NONE) begin
                  out_last_in = 1'b0;
                  state_in    = ST_SECOND;
               end else begin
                  out_last_in = (rem_sub == '0);
                  state_in    = (rem_sub == '0) ? ST_IDLE : ST_FIRST;
               end
            end
         end
         ST_SECOND: begin
            if (emit) begin
               out_valid_in = 1'b1;
               out_code_in  = sym_second(idx_ff);
               out_cv_in    = 1'b1;
               out_last_in  = (rem_ff == '0);
               state_in     = (rem_ff == '0) ? ST_IDLE : ST_FIRST;
            end
         end
         ST_ZERO: begin
            if (emit) begin
               out_valid_in = 1'b1;
               out_code_in  = CHAR_NONE;
               out_cv_in    = 1'b0;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      idx_ff      <= idx_in;
      out_code_ff <= out_code_in;
      out_cv_ff   <= out_cv_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_char_code  = out_code_ff;
   assign rsp_char_valid = out_cv_ff;
   assign rsp_last       = out_last_ff;

   // Letters are only owed while some magnitude is left
   a_first_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIRST) |-> (rem_ff != '0))
      else $error("rne_back: letter state with nothing left");

   // A pending second letter belongs to a subtractive pair
   a_second_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SECOND) |-> (sym_second(idx_ff) != CHAR_NONE))
      else $error("rne_back: second letter of a single symbol");

   // The empty beat always closes its run
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_char_valid) |-> rsp_last)
      else $error("rne_back: empty beat without last");

   // A zero item goes straight to the empty beat
   a_zero_path: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_item.zero) |=> (state_ff == ST_ZERO))
      else $error("rne_back: zero item not routed to empty beat");

endmodule

>>> sv/roman_numeral_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roman_numeral_encoder_top
// Converts a signed integer into its Roman numeral, one ASCII character per
// result beat (an empty beat for zero), with the last beat of a run marked.
//
//   Channel  Direction  Handshake           Payload
//   req      in         req_valid/req_stall req_value[12:0]
//   rsp      out        rsp_valid/rsp_stall rsp_char_code[7:0], rsp_char_valid,
//                                           rsp_last
//
// The back sequencer loads an item from the queue, then emits its characters
//   one per cycle unless the output stalls (at most 16; zero gives one empty
//   beat). It loads the next item only once the current run has ended.
// The front keeps accepting until its two-entry queue is full.
// Reset is synchronous and clears the queue, sequencer and output stage.
// A stalled output beat holds; the sequencer waits behind it.
// ----------------------------------------------------------------------------
module roman_numeral_encoder_top
   import rne_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [VALUE_W-1:0] req_value,
   output logic               req_stall,
   output logic               rsp_valid,
   output logic [CHAR_W-1:0]  rsp_char_code,
   output logic               rsp_char_valid,
   output logic               rsp_last,
   input  logic               rsp_stall
);

   logic     q_full;
   logic     q_empty;
   logic     q_push;
   logic     q_pop;
   item_type push_item;
   item_type pop_item;

   // Classify and accept input beats
   rne_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_value (req_value),
      .req_stall (req_stall),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (push_item)
   );

   // Hold classified items between the two sides
   rne_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .empty     (q_empty),
      .pop       (q_pop),
      .pop_item  (pop_item)
   );

   // Emit the characters
   rne_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_item         (pop_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_char_code  (rsp_char_code),
      .rsp_char_valid (rsp_char_valid),
      .rsp_last       (rsp_last),
      .rsp_stall      (rsp_stall)
   );

endmodule

>>> bench/tb_roman_numeral_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_roman_numeral_encoder_top
// Self-checking bench for the Roman numeral encoder. A behavioral predictor
// expands every accepted value into its expected run of character beats, and
// a monitor compares each delivered beat against the oldest expected one.
// Directed values cover every symbol, the sign, zero and saturation; random
// values then run under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_roman_numeral_encoder_top
   import rne_pkg::*;
();

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              char_valid;
      logic              last;
   } numeral_char_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic [VALUE_W-1:0] req_value = '0;
   logic               req_stall;
   logic               rsp_valid;
   logic [CHAR_W-1:0]  rsp_char_code;
   logic               rsp_char_valid;
   logic               rsp_last;
   logic               rsp_stall = 1'b0;

   numeral_char_type expected_chars[$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int error_count = 0;
   int cycle_count = 0;
   int values_sent = 0;
   int negative_count = 0;
   int zero_count = 0;
   int saturated_count = 0;
   int chars_checked = 0;

   roman_numeral_encoder_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_value      (req_value),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_char_code  (rsp_char_code),
      .rsp_char_valid (rsp_char_valid),
      .rsp_last       (rsp_last),
      .rsp_stall      (rsp_stall)
   );

   always #5 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles, %0d beats still expected",
                  cycle_count, expected_chars.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   // Symbol table, largest first
   function automatic void numeral_symbol(input int idx, output int weight,
                                          output logic [CHAR_W-1:0] lead,
                                          output logic [CHAR_W-1:0] trail);
      trail = CHAR_NONE;
      case (idx)
         0:       begin weight = 1000; lead = CHAR_M; end
         1:       begin weight = 900;  lead = CHAR_C; trail = CHAR_M; end
         2:       begin weight = 500;  lead = CHAR_D; end
         3:       begin weight = 400;  lead = CHAR_C; trail = CHAR_D; end
         4:       begin weight = 100;  lead = CHAR_C; end
         5:       begin weight = 90;   lead = CHAR_X; trail = CHAR_C; end
         6:       begin weight = 50;   lead = CHAR_L; end
         7:       begin weight = 40;   lead = CHAR_X; trail = CHAR_L; end
         8:       begin weight = 10;   lead = CHAR_X; end
         9:       begin weight = 9;    lead = CHAR_I; trail = CHAR_X; end
         10:      begin weight = 5;    lead = CHAR_V; end
         11:      begin weight = 4;    lead = CHAR_I; trail = CHAR_V; end
         default: begin weight = 1;    lead = CHAR_I; end
      endcase
   endfunction

   // Expand one value into its expected character beats
   function automatic void predict_numeral(input logic [VALUE_W-1:0] raw);
      numeral_char_type run[$];
      int mag;
      int weight;
      logic [CHAR_W-1:0] lead;
      logic [CHAR_W-1:0] trail;
      mag = raw[VALUE_W-1] ? (1 << VALUE_W) - int'(raw) : int'(raw);
      if (raw[VALUE_W-1])
         negative_count++;
      if (mag > int'(MAX_MAG)) begin
         mag = int'(MAX_MAG);
         saturated_count++;
      end
      if (mag == 0) begin
         zero_count++;
         run.push_back('{code: CHAR_NONE, char_valid: 1'b0, last: 1'b1});
      end else begin
         if (raw[VALUE_W-1])
            run.push_back('{code: CHAR_MINUS, char_valid: 1'b1, last: 1'b0});
         for (int idx = 0; idx < NUM_SYMBOLS; idx++) begin
            numeral_symbol(idx, weight, lead, trail);
            while (mag >= weight) begin
               run.push_back('{code: lead, char_valid: 1'b1, last: 1'b0});
               if (trail != CHAR_NONE)
                  run.push_back('{code: trail, char_valid: 1'b1, last: 1'b0});
               mag -= weight;
            end
         end
         run[run.size()-1].last = 1'b1;
      end
      foreach (run[i])
         expected_chars.push_back(run[i]);
   endfunction

   // Check each accepted result beat and pick the next stall
   always @(posedge clock) begin : check_beat
      numeral_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            report_error($sformatf("unexpected beat code=%02h valid=%b last=%b",
                                   rsp_char_code, rsp_char_valid, rsp_last));
         end else begin
            want = expected_chars.pop_front();
            chars_checked++;
            if (rsp_char_code !== want.code)
               report_error($sformatf("char_code exp %02h got %02h",
                                      want.code, rsp_char_code));
            if (rsp_char_valid !== want.char_valid)
               report_error($sformatf("char_valid exp %b got %b",
                                      want.char_valid, rsp_char_valid));
            if (rsp_last !== want.last)
               report_error($sformatf("last exp %b got %b", want.last, rsp_last));
         end
      end
      rsp_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
   end

   // Send one value: optional idle gap, then hold until accepted
   task automatic send_value(input logic [VALUE_W-1:0] raw);
      while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= raw;
      do
         @(posedge clock);
      while (req_stall);
      values_sent++;
      predict_numeral(raw);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: v = int'($urandom_range(0, 7998)) - 3999;
         6:                v = int'($urandom_range(0, 40)) - 20;
         7:                v = int'($urandom_range(0, (1 << VALUE_W) - 1));
         8: begin
            case ($urandom_range(0, 3))
               0:       v = 0;
               1:       v = 3999;
               2:       v = -3999;
               default: v = -4096;
            endcase
         end
         default: begin
            v = int'($urandom_range(3000, 3999));
            if ($urandom_range(0, 1))
               v = -v;
         end
      endcase
      return v[VALUE_W-1:0];
   endfunction

   task automatic wait_drained();
      while (expected_chars.size() != 0)
         @(posedge clock);
   endtask

   // Every symbol, pairs, sign and long runs
   task automatic test_symbols();
      int vals[$] = '{1, -1, 4, 9, 14, 40, 90, 400, 900, 1994, 2421, -444,
                      -949, 3888, -3888};
      foreach (vals[i])
         send_value(vals[i][VALUE_W-1:0]);
   endtask

   // Zero, range ends and saturation above 3999
   task automatic test_zero_and_saturation();
      int vals[$] = '{0, 3999, -3999, 4000, 4095, -4000, -4096, 0};
      foreach (vals[i])
         send_value(vals[i][VALUE_W-1:0]);
   endtask

   task automatic test_random_values(input int idle_pct, input int stall_mix,
                                     input int count);
      send_idle_pct = idle_pct;
      stall_pct = stall_mix;
      repeat (count)
         send_value(pick_value());
   endtask

   // Hold the sender until all output has drained, then resume
   task automatic test_drain_pause();
      send_idle_pct = 33;
      stall_pct = 33;
      repeat (4)
         send_value(pick_value());
      req_valid <= 1'b0;
      wait_drained();
      @(posedge clock);
      repeat (4)
         send_value(pick_value());
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      stall_pct = 20;
      test_symbols();
      test_zero_and_saturation();
      test_random_values(0, 0, 52);
      test_random_values(72, 0, 52);
      test_random_values(0, 72, 52);
      test_random_values(33, 33, 52);
      test_drain_pause();

      // Drop valid, drain, then let stray beats show up
      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d values (%0d negative, %0d zero, %0d saturated), %0d beats checked",
               values_sent, negative_count, zero_count, saturated_count, chars_checked);
      $display("Ran with no idling, sender gaps, receiver stalls, both, and a drain pause");
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
